// ===== sv/ctcg_pkg.sv =====
// ----------------------------------------------------------------------------
// ctcg_pkg
// Shared types and constants for the CTC greedy argmax decoder.
// ----------------------------------------------------------------------------
package ctcg_pkg;

    localparam int SCORE_W  = 16;   // Q4.12 score
    localparam int IDX_W    = 13;   // class index
    localparam int CFG_W    = 14;   // config register width
    localparam int CNT_W    = 10;   // token counter
    localparam int SUM_W    = 25;   // running score sum
    localparam int DIV_W    = 26;   // divider dividend / quotient
    localparam int DEN_W    = 11;   // divider divisor
    localparam int DCNT_W   = 5;    // divider step counter
    localparam int TDATA_W  = 40;   // output tdata, byte padded

    localparam logic [CFG_W-1:0] MAX_CLASSES = 14'd8192;
    localparam logic [CNT_W-1:0] MAX_STEPS   = 10'd512;
    localparam logic [CFG_W-1:0] CFG_RESET   = 14'd8192;

    localparam logic [DCNT_W-1:0] DIV_STEPS = 5'd26;

    localparam logic [SCORE_W-1:0] SCORE_POS_MAX = 16'h7FFF;
    localparam logic [SCORE_W-1:0] SCORE_NEG_MAX = 16'h8000;

    // config register indexes
    localparam logic CFG_CLASS_COUNT = 1'b0;
    localparam logic CFG_LABEL_COUNT = 1'b1;

    // result kinds (tuser)
    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUMMARY
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

endpackage

// ===== sv/ctcg_div.sv =====
// ----------------------------------------------------------------------------
// ctcg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctcg_div
    import ctcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [DEN_W:0] w_shift;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
            n_cnt  = DIV_STEPS;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== sv/ctc_greedy_argmax_decoder_top.sv =====
// ----------------------------------------------------------------------------
// ctc_greedy_argmax_decoder_top
// CTC greedy (best path) decoder over a stream of Q4.12 class scores.
// ----------------------------------------------------------------------------
// Scores come in one per beat, row by row, class_count beats per time step;
// tlast marks the final score of the sequence (and ends a partial row).
// Each row keeps a running argmax (ties keep the lower index). At row end
// the best index is collapsed against the previous row: a new, non-blank
// index below label_count leaves as a token beat carrying its score and the
// running token count. After the final row a summary beat carries the
// rounded mean of the token scores (0 if none). Score beats are taken back
// to back while the output is free. A sequence-ending beat with tokens
// starts the divider, one quotient bit per cycle; the input is not ready
// while it runs and the summary is handed off. A single output register
// holds each result; a new beat is taken in the same cycle the held result
// drains. Configuration writes belong between sequences.
// ----------------------------------------------------------------------------
module ctc_greedy_argmax_decoder_top
    import ctcg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // score input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [SCORE_W-1:0] i_s_axis_tdata,   // [15:0] class_score
    input  logic               i_s_axis_tlast,   // seq_end
    // result output stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // [12:0] label_index,
                                                 // [28:13] mean_score,
                                                 // [38:29] token_count, [39] 0
    output logic               o_m_axis_tuser,   // result_kind
    output logic               o_m_axis_tlast    // last
);

    // configuration
    logic [CFG_W-1:0] r_class_count;
    logic [CFG_W-1:0] r_label_count;

    // sequence / row state
    t_state                    r_state, n_state;
    logic signed [SCORE_W-1:0] r_row_max;
    logic [IDX_W-1:0]          r_row_best;
    logic [IDX_W-1:0]          r_pos;
    logic [IDX_W-1:0]          r_prev;
    logic                      r_have_prev;
    logic signed [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]          r_tok;
    logic                      r_neg;

    // output register
    logic               r_o_valid;
    logic               r_o_kind;
    logic [IDX_W-1:0]   r_o_label;
    logic [SCORE_W-1:0] r_o_score;
    logic [CNT_W-1:0]   r_o_count;
    logic               r_o_last;

    // sequencer outputs
    logic w_slot_free;
    logic w_accept;
    logic w_load_sum;

    // beat datapath
    logic signed [SCORE_W-1:0] w_score;
    logic [CFG_W-1:0]          w_eff_count;
    logic                      w_take;
    logic signed [SCORE_W-1:0] w_cur_max;
    logic [IDX_W-1:0]          w_cur_best;
    logic [CFG_W-1:0]          w_pos_inc;
    logic                      w_row_done;
    logic                      w_emit;
    logic                      w_add;
    logic [CNT_W-1:0]          w_tok_new;
    logic signed [SUM_W-1:0]   w_sum_new;
    logic [SUM_W-1:0]          w_mag;

    // divider
    t_div_req         w_div_req;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quot;
    logic [SCORE_W-1:0] w_mean;

    assign w_slot_free = !r_o_valid || i_m_axis_tready;

    // ---- sequencer: next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_s_axis_tlast) begin
                    n_state = (w_tok_new != '0) ? ST_DIV : ST_SUMMARY;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SUMMARY;
                end
            end
            ST_SUMMARY: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_load_sum      = 1'b0;
        case (r_state)
            ST_IDLE:    o_s_axis_tready = w_slot_free;
            ST_DIV:     o_s_axis_tready = 1'b0;
            ST_SUMMARY: w_load_sum      = w_slot_free;
            default:    o_s_axis_tready = 1'b0;
        endcase
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // ---- per-beat argmax and collapse ----
    assign w_score = i_s_axis_tdata;

    always_comb begin
        if (r_class_count == '0) begin
            w_eff_count = CFG_W'(1);
        end else if (r_class_count > MAX_CLASSES) begin
            w_eff_count = MAX_CLASSES;
        end else begin
            w_eff_count = r_class_count;
        end
    end

    assign w_take     = (r_pos == '0) || (w_score > r_row_max);
    assign w_cur_max  = w_take ? w_score : r_row_max;
    assign w_cur_best = w_take ? r_pos : r_row_best;
    assign w_pos_inc  = {1'b0, r_pos} + 1'b1;
    assign w_row_done = i_s_axis_tlast || (w_pos_inc >= w_eff_count);

    assign w_emit = w_row_done
                 && (!r_have_prev || (w_cur_best != r_prev))
                 && (w_cur_best != '0)
                 && ({1'b0, w_cur_best} < r_label_count);
    assign w_add  = w_emit && (r_tok < MAX_STEPS);

    assign w_tok_new = w_add ? (r_tok + 1'b1) : r_tok;
    assign w_sum_new = w_add ? (r_sum + SUM_W'(w_cur_max)) : r_sum;
    assign w_mag     = w_sum_new[SUM_W-1] ? (-w_sum_new) : w_sum_new;

    // dividend 2*|sum| + n over 2*n gives round-half-away
    assign w_div_req.start = w_accept && i_s_axis_tlast && (w_tok_new != '0);
    assign w_div_req.num   = {w_mag, 1'b0} + DIV_W'(w_tok_new);
    assign w_div_req.den   = {w_tok_new, 1'b0};

    ctcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // signed saturation of the quotient
    always_comb begin
        if (r_tok == '0) begin
            w_mean = '0;
        end else if (r_neg) begin
            w_mean = (w_quot > DIV_W'(32768)) ? SCORE_NEG_MAX : (-w_quot[SCORE_W-1:0]);
        end else begin
            w_mean = (w_quot > DIV_W'(32767)) ? SCORE_POS_MAX : w_quot[SCORE_W-1:0];
        end
    end

    // ---- state registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_class_count <= CFG_RESET;
            r_label_count <= CFG_RESET;
            r_row_max     <= '0;
            r_row_best    <= '0;
            r_pos         <= '0;
            r_prev        <= '0;
            r_have_prev   <= 1'b0;
            r_sum         <= '0;
            r_tok         <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLASS_COUNT: r_class_count <= i_cfg_data;
                    CFG_LABEL_COUNT: r_label_count <= i_cfg_data;
                    default:         r_class_count <= r_class_count;
                endcase
            end

            if (w_accept) begin
                r_row_max  <= w_cur_max;
                r_row_best <= w_cur_best;
                r_sum      <= w_sum_new;
                r_tok      <= w_tok_new;
                if (w_row_done) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= w_pos_inc[IDX_W-1:0];
                end
                if (i_s_axis_tlast) begin
                    r_prev      <= '0;
                    r_have_prev <= 1'b0;
                end else if (w_row_done) begin
                    r_prev      <= w_cur_best;
                    r_have_prev <= 1'b1;
                end
            end else if (w_load_sum) begin
                r_sum <= '0;
                r_tok <= '0;
            end

            if ((w_accept && w_emit) || w_load_sum) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_sum_new[SUM_W-1];
        end
        if (w_accept && w_emit) begin
            r_o_kind  <= KIND_TOKEN;
            r_o_label <= w_cur_best;
            r_o_score <= w_cur_max;
            r_o_count <= w_tok_new;
            r_o_last  <= !i_s_axis_tlast;
        end else if (w_load_sum) begin
            r_o_kind  <= KIND_SUMMARY;
            r_o_label <= '0;
            r_o_score <= w_mean;
            r_o_count <= r_tok;
            r_o_last  <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {1'b0, r_o_count, r_o_score, r_o_label};
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CTC greedy argmax decoder.
// ----------------------------------------------------------------------------
// Score beats are pushed in rows, and every accepted beat runs through a
// behavioral decoder kept here (running argmax, repeat collapse, blank and
// label cut, token sum and rounded mean). The tokens and summaries that it
// predicts wait in a queue. A monitor compares each result beat that leaves
// the block with the oldest prediction, field by field. The sender works in
// bursts with gaps. The receiver stalls on its own pattern and once holds
// off long enough to fill the block.
// ----------------------------------------------------------------------------
module testbench;
    import ctcg_pkg::*;

    // receiver stall styles
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    localparam int DRAIN_CYCLES  = 40;      // divider run + handoff, with margin
    localparam int RANDOM_BEATS  = 60;      // random phase; directed tests carry the rest
    localparam int MAX_MISMATCH_PRINTS = 200;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [SCORE_W-1:0] i_s_axis_tdata;     // [15:0] class_score
    logic               i_s_axis_tlast;     // seq_end
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [TDATA_W-1:0] o_m_axis_tdata;     // [12:0] label_index, [28:13] mean_score,
                                            // [38:29] token_count, [39] 0
    logic               o_m_axis_tuser;     // result_kind
    logic               o_m_axis_tlast;     // last

    ctc_greedy_argmax_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // one predicted result beat: token or sequence summary
    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   label;
        logic [SCORE_W-1:0] score;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_decoded;

    t_decoded decoded_q[$];

    // decoder copy: registers
    logic [CFG_W-1:0] reg_class_count;
    logic [CFG_W-1:0] reg_label_count;
    // decoder copy: row and sequence state
    logic signed [SCORE_W-1:0] cur_max;
    int     cur_best;
    int     cls_pos;
    int     last_best;
    bit     seen_row;
    longint sum_acc;
    int     n_tokens;

    // bookkeeping
    int errors;
    int beats_sent;
    int tokens_checked;
    int summaries_checked;
    int cfg_writes;

    // sender / receiver idling controls
    bit       gaps_on;
    int       gap_max;
    int       burst_left;
    int       rx_mode;
    logic [7:0] rx_pattern;
    int       rx_phase;
    int       hold_cycles;

    // ------------------------------------------------------------------------
    // clock, run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // far beyond the slowest legal run
    initial begin
        #(8 * 1_500_000);
        $display("run limit hit at %0t with %0d results pending", $time, decoded_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic [SCORE_W-1:0] mean_token_score();
        longint mag;
        longint q;
        if (n_tokens == 0) begin
            return '0;
        end
        mag = (sum_acc < 0) ? -sum_acc : sum_acc;
        q   = (mag * 2 + n_tokens) / (2 * n_tokens);   // round half away from zero
        if (sum_acc < 0) begin
            q = -q;
        end
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return q[SCORE_W-1:0];
    endfunction

    task automatic clear_decoder();
        cur_max   = '0;
        cur_best  = 0;
        cls_pos   = 0;
        last_best = 0;
        seen_row  = 1'b0;
        sum_acc   = 0;
        n_tokens  = 0;
    endtask

    // advance the decoder copy by one accepted score beat
    task automatic decode_score(input logic signed [SCORE_W-1:0] score, input logic seq_end);
        int       n_cls;
        t_decoded r;
        n_cls = reg_class_count;
        if (n_cls == 0) begin
            n_cls = 1;
        end
        if (n_cls > int'(MAX_CLASSES)) begin
            n_cls = int'(MAX_CLASSES);
        end
        // first score of a row always loads; later ones only if strictly greater
        if (cls_pos == 0 || score > cur_max) begin
            cur_max  = score;
            cur_best = cls_pos;
        end
        if (!seq_end && (cls_pos + 1 < n_cls)) begin
            cls_pos = (cls_pos + 1) % 8192;
        end else begin
            cls_pos = 0;
            if ((!seen_row || cur_best != last_best) && cur_best != 0 &&
                cur_best < int'(reg_label_count)) begin
                // past MAX_STEPS tokens still leave, but are neither counted nor summed
                if (n_tokens < int'(MAX_STEPS)) begin
                    n_tokens++;
                    sum_acc += cur_max;
                end
                r.kind  = KIND_TOKEN;
                r.label = cur_best[IDX_W-1:0];
                r.score = cur_max;
                r.count = n_tokens[CNT_W-1:0];
                r.last  = !seq_end;
                decoded_q.insert(decoded_q.size(), r);
            end
            last_best = cur_best;
            seen_row  = 1'b1;
            if (seq_end) begin
                r.kind  = KIND_SUMMARY;
                r.label = '0;
                r.score = mean_token_score();
                r.count = n_tokens[CNT_W-1:0];
                r.last  = 1'b1;
                decoded_q.insert(decoded_q.size(), r);
                clear_decoder();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result monitor: sample at the rising edge, compare with the oldest entry
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= MAX_MISMATCH_PRINTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            end
        end
    endtask

    initial begin
        t_decoded r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_MISMATCH_PRINTS) begin
                        $display("%0t: unexpected result beat, expected none, actual tdata %0h",
                                 $time, o_m_axis_tdata);
                    end
                end else begin
                    r = decoded_q.pop_front();
                    check_field("result_kind", r.kind,  o_m_axis_tuser);
                    check_field("label_index", r.label, o_m_axis_tdata[12:0]);
                    check_field("mean_score",  r.score, o_m_axis_tdata[28:13]);
                    check_field("token_count", r.count, o_m_axis_tdata[38:29]);
                    check_field("last",        r.last,  o_m_axis_tlast);
                    if (r.kind == KIND_SUMMARY) begin
                        summaries_checked++;
                    end else begin
                        tokens_checked++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: long hold-off when asked, else its own stall style
    // ------------------------------------------------------------------------
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_m_axis_tready = 1'b0;
                hold_cycles--;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        i_m_axis_tready = 1'b1;
                    end
                    RX_RANDOM: begin
                        i_m_axis_tready = ($urandom_range(99, 0) < 65);
                    end
                    RX_PATTERN: begin
                        i_m_axis_tready = rx_pattern[rx_phase];
                        rx_phase = (rx_phase + 1) % 8;
                    end
                    default: begin
                        i_m_axis_tready = 1'b1;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side helpers
    // ------------------------------------------------------------------------
    // one score beat: optional gap between bursts, then hold until accepted
    task automatic send_beat(input logic [SCORE_W-1:0] score, input logic seq_end);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(gap_max, 1);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
            end
            burst_left = $urandom_range(24, 1);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = score;
        i_s_axis_tlast  = seq_end;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        decode_score(score, seq_end);
        beats_sent++;
    endtask

    // block idle: input quiet, all predictions drained, divider settled
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tlast  = 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (index == CFG_CLASS_COUNT) begin
            reg_class_count = value;
        end else begin
            reg_label_count = value;
        end
        cfg_writes++;
    endtask

    task automatic set_counts(input int n_cls, input int n_lbl);
        write_reg(CFG_CLASS_COUNT, n_cls[CFG_W-1:0]);
        write_reg(CFG_LABEL_COUNT, n_lbl[CFG_W-1:0]);
    endtask

    task automatic pick_idle_style();
        gaps_on    = ($urandom_range(2, 0) != 0);
        gap_max    = $urandom_range(8, 1);
        burst_left = 0;
        rx_mode    = $urandom_range(2, 0);
        rx_pattern = 8'($urandom()) | 8'h01;
    endtask

    // peak score of a row; the floor only where nothing has to sit below it
    function automatic int pick_peak(input int winner);
        int w;
        case ($urandom_range(9, 0))
            0: w = 32767;
            1: w = (winner == 0) ? -32768 : -32767;
            default: w = int'($urandom_range(65534, 0)) - 32767;
        endcase
        return w;
    endfunction

    function automatic int score_below(input int w);
        if (w <= -32768) begin
            return w;
        end
        return int'($urandom_range(w + 32767, 0)) - 32768;
    endfunction

    // one row of len beats; winner < 0 means fully random scores.
    // Before the winner scores sit strictly below the peak, after it they may tie.
    task automatic send_row(input int winner, input int len, input bit end_seq);
        int w;
        int s;
        w = pick_peak(winner);
        for (int p = 0; p < len; p++) begin
            if (winner < 0) begin
                s = int'($urandom_range(65535, 0)) - 32768;
            end else if (p == winner) begin
                s = w;
            end else if (p > winner && $urandom_range(4, 0) == 0) begin
                s = w;
            end else begin
                s = score_below(w);
            end
            send_beat(s[SCORE_W-1:0], end_seq && (p == len - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset counts (8192 each): the row is cut short by seq_end; extremes and a tie
    task automatic test_defaults_and_ties();
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        send_beat(SCORE_NEG_MAX, 1'b0);
        send_beat(SCORE_POS_MAX, 1'b0);
        send_beat(SCORE_POS_MAX, 1'b1);   // tie keeps index 1
    endtask

    task automatic test_register_extremes();
        set_counts(1, 8192);              // single-class rows: always blank
        send_row(0, 2, 1'b1);
        set_counts(0, 8192);              // zero acts as one class
        send_row(0, 1, 1'b1);
        set_counts(16383, 16383);         // above the maximum acts as 8192
        send_row(2, 3, 1'b1);
        set_counts(2, 0);                 // no label is ever valid
        send_row(1, 2, 1'b1);
    endtask

    // repeats collapse, a blank row separates equal indices, label cut-off
    task automatic test_collapse_and_labels();
        set_counts(2, 8192);
        send_row(1, 2, 1'b0);
        send_row(1, 2, 1'b0);
        send_row(0, 2, 1'b0);
        send_row(1, 2, 1'b1);
        write_reg(CFG_LABEL_COUNT, 14'd1);
        send_row(1, 2, 1'b0);
        send_row(1, 2, 1'b1);
    endtask

    // count lowered while a row is open: the row ends at the next beat
    task automatic test_count_change_mid_row();
        set_counts(4, 8192);
        send_beat(16'h0100, 1'b0);
        send_beat(16'h0200, 1'b0);
        write_reg(CFG_CLASS_COUNT, 14'd2);
        send_beat(16'h0300, 1'b0);
        send_row(1, 2, 1'b1);
    endtask

    // receiver stops for a long stretch while the sender keeps offering beats
    task automatic test_backpressure();
        set_counts(2, 8192);
        gaps_on = 1'b0;
        rx_mode = RX_RANDOM;
        hold_cycles = 400;
        for (int row = 0; row < 40; row++) begin
            send_row((row % 2 == 0) ? 1 : 0, 2, row == 39);
        end
    endtask

    // more than MAX_STEPS tokens in one sequence, then a fresh short one.
    // Rows alternate between two classes (peak 1) and three classes (peak 2),
    // so every row leaves a token at few beats per row.
    task automatic test_token_overflow();
        set_counts(2, 8192);
        pick_idle_style();
        for (int row = 0; row < 514; row++) begin
            if (row % 2 == 0) begin
                write_reg(CFG_CLASS_COUNT, 14'd2);
                send_row(1, 2, row == 513);
            end else begin
                write_reg(CFG_CLASS_COUNT, 14'd3);
                send_row(2, 3, row == 513);
            end
        end
        send_row(2, 3, 1'b1);
    endtask

    task automatic random_sequence(input int n_eff);
        int rows;
        int len;
        int winner;
        int prev_w;
        int pick;
        if (n_eff >= int'(MAX_CLASSES)) begin
            // huge rows: only short sequences cut by seq_end
            len = $urandom_range(6, 1);
            winner = ($urandom_range(3, 0) == 0) ? -1 : $urandom_range(len - 1, 0);
            send_row(winner, len, 1'b1);
        end else begin
            rows   = $urandom_range(10, 1);
            prev_w = 0;
            for (int row = 0; row < rows; row++) begin
                pick = $urandom_range(9, 0);
                if (pick < 2) begin
                    winner = -1;
                end else if (pick < 4) begin
                    winner = 0;
                end else if (pick < 6) begin
                    winner = prev_w;
                end else begin
                    winner = $urandom_range(n_eff - 1, 0);
                end
                len = n_eff;
                if (row == rows - 1 && $urandom_range(3, 0) == 0) begin
                    len = $urandom_range(n_eff, 1);   // early end inside the row
                end
                send_row(winner, len, row == rows - 1);
                if (winner >= 0) begin
                    prev_w = winner;
                end
            end
        end
    endtask

    task automatic test_random_sequences();
        int start;
        int n_cls;
        int n_eff;
        int n_lbl;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            case ($urandom_range(11, 0))
                0: n_cls = 0;
                1: n_cls = 1;
                2: n_cls = $urandom_range(16383, 8193);
                3: n_cls = 8192;
                default: n_cls = $urandom_range(8, 2);
            endcase
            n_eff = (n_cls == 0) ? 1 : ((n_cls > 8192) ? 8192 : n_cls);
            case ($urandom_range(7, 0))
                0: n_lbl = 0;
                1: n_lbl = 16383;
                2: n_lbl = 8192;
                default: n_lbl = $urandom_range((n_eff > 8) ? 8 : n_eff, 1);
            endcase
            set_counts(n_cls, n_lbl);
            pick_idle_style();
            repeat ($urandom_range(5, 1)) begin
                if (beats_sent - start < RANDOM_BEATS) begin
                    random_sequence(n_eff);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_CLASS_COUNT;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        errors            = 0;
        beats_sent        = 0;
        tokens_checked    = 0;
        summaries_checked = 0;
        cfg_writes        = 0;
        gaps_on     = 1'b0;
        gap_max     = 1;
        burst_left  = 0;
        rx_mode     = RX_ALWAYS;
        rx_pattern  = 8'hFF;
        rx_phase    = 0;
        hold_cycles = 0;
        reg_class_count = CFG_RESET;
        reg_label_count = CFG_RESET;
        clear_decoder();

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        test_defaults_and_ties();
        test_register_extremes();
        test_collapse_and_labels();
        test_count_change_mid_row();
        test_backpressure();
        test_token_overflow();
        test_random_sequences();

        wait_drained();
        $display("Sent %0d score beats over %0d register writes; checked %0d tokens, %0d summaries",
                 beats_sent, cfg_writes, tokens_checked, summaries_checked);
        $display("Covered count limits, collapse, label cut, early end, token overflow, stalls");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
